@@ rtl/ghmm_pkg.sv @@
// ----------------------------------------------------------------------------
// ghmm_pkg
// Shared constants, codes and types for the grid histogram with min/max scan.
// ----------------------------------------------------------------------------
package ghmm_pkg;

    // Default grid geometry and count width
    localparam int GRID_COLS_DEF  = 32;
    localparam int GRID_ROWS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int POS_W    = 20;   // signed Q16.4 coordinate
    localparam int SPAN_W   = 19;   // configuration registers
    localparam int OFF_W    = 20;   // offset from the lower edge, unsigned
    localparam int SEL_W    = 5;    // read_col / read_row / tile_col / tile_row
    localparam int MM_W     = 20;   // min_count / max_count
    localparam int TCNT_W   = 16;   // tile_count
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;

    // Scan cap for reported min and max
    localparam logic [MM_W-1:0] SCAN_CAP = 20'd1000000;

    // Input item kinds
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd3;

    // Configuration reset values
    localparam logic [SPAN_W-1:0] HALF_SPAN_X_RST = 19'd32000;
    localparam logic [SPAN_W-1:0] HALF_SPAN_Y_RST = 19'd16000;
    localparam logic [SPAN_W-1:0] TILE_WIDTH_RST  = 19'd2000;
    localparam logic [SPAN_W-1:0] TILE_HEIGHT_RST = 19'd1000;

    // Request to the shared binning divider
    typedef struct packed {
        logic              start;
        logic [OFF_W-1:0]  dividend;
        logic [SPAN_W-1:0] divisor;
    } div_req_t;

endpackage

@@ rtl/ghmm_bin_div.sv @@
// ----------------------------------------------------------------------------
// ghmm_bin_div
// Shared repeated-subtraction unit: quotient of an offset by a tile size,
// clamped to a limit. One subtract and compare per cycle.
// ----------------------------------------------------------------------------
module ghmm_bin_div #(
    parameter int QW = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ghmm_pkg::div_req_t req,
    input  logic [QW-1:0]     limit,
    output logic              done,
    output logic [QW-1:0]     quot
);

    logic                        busy_reg, busy_next;
    logic [ghmm_pkg::OFF_W-1:0]  rem_reg, rem_next;
    logic [ghmm_pkg::SPAN_W-1:0] dsr_reg, dsr_next;
    logic [QW-1:0]               lim_reg, lim_next;
    logic [QW-1:0]               q_reg, q_next;
    logic                        stop;

    // Stop once the limit is reached or the remainder no longer holds a tile
    assign stop = (q_reg == lim_reg) ||
                  (rem_reg < ghmm_pkg::OFF_W'(dsr_reg));
    assign done = busy_reg && stop;
    assign quot = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        lim_next  = lim_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = req.dividend;
            dsr_next  = req.divisor;
            lim_next  = limit;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (stop)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = rem_reg - ghmm_pkg::OFF_W'(dsr_reg);
                q_next   = q_reg + QW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        lim_reg <= lim_next;
        q_reg   <= q_next;
    end

endmodule

@@ rtl/grid_histogram_min_max.sv @@
// ----------------------------------------------------------------------------
// grid_histogram_min_max
// 2-D grid histogram of tile counts with a frame scan that reports min/max.
// ----------------------------------------------------------------------------
// Work per item: a point in span has its column and row indexes found by
//   repeated subtraction in the shared divider, then its tile count incremented;
//   a frame scan walks every tile (one tile a cycle through the live-count port);
//   a read fetches one frame count if on the grid; other items go to the result.
// Throughput: one item at a time, the next taken the cycle after a result parks.
// Reset: registers to reset values, then both count memories cleared in full.
// ----------------------------------------------------------------------------
module grid_histogram_min_max #(
    parameter int GRID_COLS  = ghmm_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = ghmm_pkg::GRID_ROWS_DEF,
    parameter int COUNT_BITS = ghmm_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x[19:0], pos_y[39:20], read_col[44:40], read_row[49:45], zero pad
    input  logic [ghmm_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  logic [ghmm_pkg::MODE_W-1:0]         s_tuser,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // in_range[0], tile_col[5:1], tile_row[10:6], min_count[30:11],
    // max_count[50:31], tile_count[66:51], zero pad
    output logic [ghmm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [ghmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ghmm_pkg::SPAN_W-1:0]         cfg_data
);

    localparam int NTILES = GRID_COLS * GRID_ROWS;
    localparam int AW     = $clog2(NTILES);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int QW     = (CW > RW) ? CW : RW;
    localparam int SW     = (COUNT_BITS > ghmm_pkg::MM_W) ? COUNT_BITS : ghmm_pkg::MM_W;
    localparam int EW     = (COUNT_BITS > ghmm_pkg::TCNT_W) ? COUNT_BITS : ghmm_pkg::TCNT_W;

    // Sequencer states
    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_CHECK     = 4'd2;
    localparam logic [3:0] S_DIVX      = 4'd3;
    localparam logic [3:0] S_DIVY      = 4'd4;
    localparam logic [3:0] S_INCR_RD   = 4'd5;
    localparam logic [3:0] S_INCR_WR   = 4'd6;
    localparam logic [3:0] S_SCAN      = 4'd7;
    localparam logic [3:0] S_SCAN_END  = 4'd8;
    localparam logic [3:0] S_READ      = 4'd9;
    localparam logic [3:0] S_READ_WAIT = 4'd10;
    localparam logic [3:0] S_RESULT    = 4'd11;

    logic [3:0] state_reg, state_next;

    // Configuration registers
    logic [ghmm_pkg::SPAN_W-1:0] half_span_x_reg, half_span_y_reg;
    logic [ghmm_pkg::SPAN_W-1:0] tile_width_reg, tile_height_reg;

    // Latched input item
    logic signed [ghmm_pkg::POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [ghmm_pkg::POS_W-1:0] pos_y_reg, pos_y_next;
    logic [ghmm_pkg::SEL_W-1:0]        read_col_reg, read_col_next;
    logic [ghmm_pkg::SEL_W-1:0]        read_row_reg, read_row_next;

    // Working registers
    logic [ghmm_pkg::OFF_W-1:0] off_y_reg, off_y_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [AW:0]                cnt_reg, cnt_next;
    logic                       pv_reg, pv_next;
    logic [AW-1:0]              paddr_reg, paddr_next;
    logic [SW-1:0]              mn_reg, mn_next;
    logic [SW-1:0]              mx_reg, mx_next;

    // Result fields
    logic                        res_in_range_reg, res_in_range_next;
    logic [ghmm_pkg::SEL_W-1:0]  res_col_reg, res_col_next;
    logic [ghmm_pkg::SEL_W-1:0]  res_row_reg, res_row_next;
    logic [ghmm_pkg::MM_W-1:0]   res_min_reg, res_min_next;
    logic [ghmm_pkg::MM_W-1:0]   res_max_reg, res_max_next;
    logic [ghmm_pkg::TCNT_W-1:0] res_cnt_reg, res_cnt_next;

    // Output register
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ghmm_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Count memories
    logic [COUNT_BITS-1:0] live_mem [NTILES];
    logic [COUNT_BITS-1:0] frame_mem [NTILES];
    logic [COUNT_BITS-1:0] live_rd_reg, frame_rd_reg;
    logic                  live_we, frame_we;
    logic [AW-1:0]         live_waddr, frame_waddr, live_raddr, frame_raddr;
    logic [COUNT_BITS-1:0] live_wdata, frame_wdata;

    // Shared divider
    ghmm_pkg::div_req_t div_req;
    logic [QW-1:0]      div_limit;
    logic               div_done;
    logic [QW-1:0]      div_quot;

    // Range check datapath
    logic signed [ghmm_pkg::POS_W:0] sx, sy, hx, hy, offx, offy;
    logic                            out_of_span;

    // Scan and read helpers
    logic [SW-1:0] cnt_ext;
    logic [SW-1:0] mn_fin, mx_fin;
    logic [EW-1:0] frame_ext;
    logic          read_in_grid;
    logic          out_load;

    ghmm_bin_div #(
        .QW (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .limit (div_limit),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sign-extend the point, zero-extend the span, then test both axes at once
    assign sx = {pos_x_reg[ghmm_pkg::POS_W-1], pos_x_reg};
    assign sy = {pos_y_reg[ghmm_pkg::POS_W-1], pos_y_reg};
    assign hx = {2'b00, half_span_x_reg};
    assign hy = {2'b00, half_span_y_reg};
    assign offx = sx + hx;
    assign offy = sy + hy;
    assign out_of_span = (sx < -hx) || (sx > hx) || (sy < -hy) || (sy > hy);

    assign cnt_ext   = SW'(live_rd_reg);
    assign frame_ext = EW'(frame_rd_reg);

    // Degenerate scan where every tile matches: report the fixed pair; else clamp both to the scan cap
    always_comb
    begin
        if (mn_reg == mx_reg)
        begin
            mn_fin = '0;
            mx_fin = SW'(ghmm_pkg::SCAN_CAP);
        end
        else
        begin
            mn_fin = (mn_reg > SW'(ghmm_pkg::SCAN_CAP)) ? SW'(ghmm_pkg::SCAN_CAP) : mn_reg;
            mx_fin = (mx_reg > SW'(ghmm_pkg::SCAN_CAP)) ? SW'(ghmm_pkg::SCAN_CAP) : mx_reg;
        end
    end

    assign read_in_grid = (32'(read_col_reg) < GRID_COLS) && (32'(read_row_reg) < GRID_ROWS);

    // Free the output register when it is empty or being taken
    assign out_load = (state_reg == S_RESULT) && (!m_tvalid_reg || m_tready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_span_x_reg <= ghmm_pkg::HALF_SPAN_X_RST;
            half_span_y_reg <= ghmm_pkg::HALF_SPAN_Y_RST;
            tile_width_reg  <= ghmm_pkg::TILE_WIDTH_RST;
            tile_height_reg <= ghmm_pkg::TILE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ghmm_pkg::CFG_HALF_SPAN_X: half_span_x_reg <= cfg_data;
                ghmm_pkg::CFG_HALF_SPAN_Y: half_span_y_reg <= cfg_data;
                ghmm_pkg::CFG_TILE_WIDTH:  tile_width_reg  <= cfg_data;
                ghmm_pkg::CFG_TILE_HEIGHT: tile_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        read_col_next     = read_col_reg;
        read_row_next     = read_row_reg;
        off_y_next        = off_y_reg;
        col_next          = col_reg;
        addr_next         = addr_reg;
        cnt_next          = cnt_reg;
        pv_next           = 1'b0;
        paddr_next        = paddr_reg;
        mn_next           = mn_reg;
        mx_next           = mx_reg;
        res_in_range_next = res_in_range_reg;
        res_col_next      = res_col_reg;
        res_row_next      = res_row_reg;
        res_min_next      = res_min_reg;
        res_max_next      = res_max_reg;
        res_cnt_next      = res_cnt_reg;

        div_req.start    = 1'b0;
        div_req.dividend = offx[ghmm_pkg::OFF_W-1:0];
        div_req.divisor  = tile_width_reg;
        div_limit        = QW'(GRID_COLS - 1);

        live_we     = 1'b0;
        live_waddr  = addr_reg;
        live_wdata  = '0;
        live_raddr  = addr_reg;
        frame_we    = 1'b0;
        frame_waddr = paddr_reg;
        frame_wdata = live_rd_reg;
        frame_raddr = addr_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one entry of each memory per cycle
                live_we     = 1'b1;
                live_waddr  = cnt_reg[AW-1:0];
                frame_we    = 1'b1;
                frame_waddr = cnt_reg[AW-1:0];
                frame_wdata = '0;
                if (cnt_reg == (AW+1)'(NTILES - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_x_next        = s_tdata[19:0];
                    pos_y_next        = s_tdata[39:20];
                    read_col_next     = s_tdata[44:40];
                    read_row_next     = s_tdata[49:45];
                    res_in_range_next = 1'b0;
                    res_col_next      = '0;
                    res_row_next      = '0;
                    res_min_next      = '0;
                    res_max_next      = '0;
                    res_cnt_next      = '0;
                    cnt_next          = '0;
                    mn_next           = SW'(ghmm_pkg::SCAN_CAP);
                    mx_next           = '0;
                    unique case (s_tuser)
                        ghmm_pkg::MODE_POINT: state_next = S_CHECK;
                        ghmm_pkg::MODE_SCAN:  state_next = S_SCAN;
                        ghmm_pkg::MODE_READ:  state_next = S_READ;
                        default:              state_next = S_RESULT;
                    endcase
                end
            end

            S_CHECK:
            begin
                if (out_of_span)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    off_y_next    = offy[ghmm_pkg::OFF_W-1:0];
                    div_req.start = 1'b1;
                    state_next    = S_DIVX;
                end
            end

            S_DIVX:
            begin
                if (div_done)
                begin
                    // Column found: reuse the divider for the row
                    col_next         = div_quot[CW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = off_y_reg;
                    div_req.divisor  = tile_height_reg;
                    div_limit        = QW'(GRID_ROWS - 1);
                    state_next       = S_DIVY;
                end
            end

            S_DIVY:
            begin
                div_limit = QW'(GRID_ROWS - 1);
                if (div_done)
                begin
                    addr_next         = AW'(col_reg) * AW'(GRID_ROWS) + AW'(div_quot[RW-1:0]);
                    res_in_range_next = 1'b1;
                    res_col_next      = ghmm_pkg::SEL_W'(col_reg);
                    res_row_next      = ghmm_pkg::SEL_W'(div_quot[RW-1:0]);
                    state_next        = S_INCR_RD;
                end
            end

            S_INCR_RD:
            begin
                state_next = S_INCR_WR;
            end

            S_INCR_WR:
            begin
                // Saturating increment of the tile count
                live_we    = 1'b1;
                live_wdata = (live_rd_reg == '1) ? live_rd_reg
                                                 : live_rd_reg + COUNT_BITS'(1);
                state_next = S_RESULT;
            end

            S_SCAN:
            begin
                // Read tile i while tile i-1 is copied, cleared and compared
                live_raddr = cnt_reg[AW-1:0];
                if (cnt_reg != (AW+1)'(NTILES))
                begin
                    pv_next    = 1'b1;
                    paddr_next = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + (AW+1)'(1);
                end
                if (pv_reg)
                begin
                    frame_we   = 1'b1;
                    live_we    = 1'b1;
                    live_waddr = paddr_reg;
                    if (cnt_ext < mn_reg)
                    begin
                        mn_next = cnt_ext;
                    end
                    if (cnt_ext > mx_reg)
                    begin
                        mx_next = cnt_ext;
                    end
                    if (cnt_reg == (AW+1)'(NTILES))
                    begin
                        state_next = S_SCAN_END;
                    end
                end
            end

            S_SCAN_END:
            begin
                res_min_next = mn_fin[ghmm_pkg::MM_W-1:0];
                res_max_next = mx_fin[ghmm_pkg::MM_W-1:0];
                state_next   = S_RESULT;
            end

            S_READ:
            begin
                frame_raddr = AW'(read_col_reg) * AW'(GRID_ROWS) + AW'(read_row_reg);
                state_next  = read_in_grid ? S_READ_WAIT : S_RESULT;
            end

            S_READ_WAIT:
            begin
                res_cnt_next = (frame_ext > EW'(16'hFFFF)) ? '1
                                                           : frame_ext[ghmm_pkg::TCNT_W-1:0];
                state_next   = S_RESULT;
            end

            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: hold until taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, res_cnt_reg, res_max_reg, res_min_reg,
                             res_row_reg, res_col_reg, res_in_range_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pv_reg       <= pv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg        <= pos_x_next;
        pos_y_reg        <= pos_y_next;
        read_col_reg     <= read_col_next;
        read_row_reg     <= read_row_next;
        off_y_reg        <= off_y_next;
        col_reg          <= col_next;
        addr_reg         <= addr_next;
        paddr_reg        <= paddr_next;
        mn_reg           <= mn_next;
        mx_reg           <= mx_next;
        res_in_range_reg <= res_in_range_next;
        res_col_reg      <= res_col_next;
        res_row_reg      <= res_row_next;
        res_min_reg      <= res_min_next;
        res_max_reg      <= res_max_next;
        res_cnt_reg      <= res_cnt_next;
        m_tdata_reg      <= m_tdata_next;
    end

    // Live counts: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        live_rd_reg <= live_mem[live_raddr];
    end

    // Frame counts: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rd_reg <= frame_mem[frame_raddr];
    end

endmodule

@@ rtl/ghmm_checker.sv @@
// ----------------------------------------------------------------------------
// ghmm_checker
// Port-level checks for the grid histogram, bound to the top level.
// ----------------------------------------------------------------------------
module ghmm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ghmm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // One item at a time: busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // A rejected or non-point item carries no tile coordinates
    a_no_tile_when_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
        else $error("tile coordinates set on an uncounted item");

    // Reported min and max never exceed the scan cap
    a_scan_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[30:11] <= ghmm_pkg::SCAN_CAP) &&
                     (m_tdata[50:31] <= ghmm_pkg::SCAN_CAP))
        else $error("scan result above cap");

endmodule

bind grid_histogram_min_max ghmm_checker u_ghmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
